### rtl/ctf_pkg.sv
`timescale 1ns / 1ps

package ctf_pkg;

   localparam int FIELD_MAX_DEFAULT = 64;
   localparam int CMD_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 4;

   localparam logic [7:0] SEPARATOR_RESET = 8'd44;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0d;
   localparam logic [7:0] CHAR_LF         = 8'h0a;

   localparam logic [1:0] KIND_SPACE = 2'd0;
   localparam logic [1:0] KIND_TAB   = 2'd1;
   localparam logic [1:0] KIND_CR    = 2'd2;
   localparam logic [1:0] KIND_LF    = 2'd3;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       last_of_line;
   } req_type;

   typedef struct packed {
      logic [7:0] field_byte;
      logic       byte_valid;
      logic       field_end;
      logic       line_end;
   } rsp_type;

   // work handed from front to back, one per accepted request that does anything
   typedef struct packed {
      logic [7:0] data;
      logic       keep;
      logic       hold;
      logic       fin;
      logic       last;
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_LEAD   = 3'd0,
      MODE_QUOTED = 3'd1,
      MODE_QSEEN  = 3'd2,
      MODE_AFTER  = 3'd3,
      MODE_PLAIN  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      BACK_HEAD  = 2'd0,
      BACK_FLUSH = 2'd1,
      BACK_BYTE  = 2'd2,
      BACK_FIN   = 2'd3
   } back_state_type;

   function automatic logic [1:0] kind_of(input logic [7:0] c);
      logic [1:0] k;
      k = KIND_LF;
      if (c == CHAR_SPACE) begin
         k = KIND_SPACE;
      end else if (c == CHAR_TAB) begin
         k = KIND_TAB;
      end else if (c == CHAR_CR) begin
         k = KIND_CR;
      end
      return k;
   endfunction

   function automatic logic [7:0] kind_char(input logic [1:0] k);
      logic [7:0] c;
      unique case (k)
         KIND_SPACE: c = CHAR_SPACE;
         KIND_TAB:   c = CHAR_TAB;
         KIND_CR:    c = CHAR_CR;
         default:    c = CHAR_LF;
      endcase
      return c;
   endfunction

endpackage

### rtl/csv_field_tokenizer_top.sv
`timescale 1ns / 1ps

// channel    ports                                  moves
// request    req_push, req_full, req_data           one line byte and its last-of-line mark
// response   rsp_pop, rsp_empty, rsp_data           one field byte, or a field end mark
// csr        csr_we, csr_wdata                      separator byte, reset 44
//
// the front takes one request per cycle while its command queue has room
// the back stores each held whitespace byte without a response; each response waits while the response queue is full
// a dropped byte, such as leading whitespace or a byte past the limit, gives the back no work unless it ends the field
// a byte after held whitespace bytes passes through the head state, which starts the read of
//   the held store, then through the flush of the held bytes, then the byte itself
// reset is synchronous and active high; it clears parse state and both queues
// either side may stall freely; the queues absorb the difference

module csv_field_tokenizer_top #(
   parameter int FIELD_MAX = ctf_pkg::FIELD_MAX_DEFAULT,
   parameter int CMD_DEPTH = ctf_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = ctf_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata,
   input  logic             req_push,
   output logic             req_full,
   input  ctf_pkg::req_type req_data,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output ctf_pkg::rsp_type rsp_data
);

   import ctf_pkg::*;

   cmd_type cmd_in, cmd_out;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   rsp_type res;
   logic    res_push, res_full;

   ctf_front #(
      .FIELD_MAX(FIELD_MAX)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_in)
   );

   ctf_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .full   (cmd_full),
      .wr_data(cmd_in),
      .pop    (cmd_pop),
      .empty  (cmd_empty),
      .rd_data(cmd_out)
   );

   ctf_back #(
      .FIELD_MAX(FIELD_MAX)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_out),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .res      (res),
      .res_push (res_push),
      .res_full (res_full)
   );

   ctf_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (res_push),
      .full   (res_full),
      .wr_data(res),
      .pop    (rsp_pop),
      .empty  (rsp_empty),
      .rd_data(rsp_data)
   );

endmodule

### rtl/ctf_fifo.sv
`timescale 1ns / 1ps

module ctf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ctf_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign push_ok = push & ~full;
   assign pop_ok  = pop & ~empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");
`endif

endmodule

### rtl/ctf_front.sv
`timescale 1ns / 1ps

module ctf_front #(
   parameter int FIELD_MAX = ctf_pkg::FIELD_MAX_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata,
   input  logic             req_push,
   output logic             req_full,
   input  ctf_pkg::req_type req_data,
   output logic             cmd_push,
   input  logic             cmd_full,
   output ctf_pkg::cmd_type cmd_data
);

   import ctf_pkg::*;

   localparam int CNT_W = $clog2(FIELD_MAX);
   localparam logic [CNT_W-1:0] KEEP_MAX = CNT_W'(FIELD_MAX - 1);

   logic [7:0]       separator_ff;
   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic             accept;
   logic             keep, hold, fin;
   logic [7:0]       c;
   logic             last;
   logic             is_quote, is_blank, is_ws, is_sep, room;

   assign accept   = req_push & ~cmd_full;
   assign req_full = cmd_full;
   assign c        = req_data.line_byte;
   assign last     = req_data.last_of_line;
   assign is_quote = (c == CHAR_QUOTE);
   assign is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
   assign is_ws    = is_blank || (c == CHAR_CR) || (c == CHAR_LF);
   assign is_sep   = (c == separator_ff);
   assign room     = (stored_ff < KEEP_MAX);

   always_comb begin
      mode_in   = mode_ff;
      stored_in = stored_ff;
      keep      = 1'b0;
      hold      = 1'b0;
      fin       = 1'b0;
      if (accept) begin
         unique case (mode_ff)
            MODE_QUOTED: begin
               if (is_quote) begin
                  if (last) begin
                     fin = 1'b1;
                  end else begin
                     mode_in = MODE_QSEEN;
                  end
               end else begin
                  if (room) begin
                     keep      = 1'b1;
                     stored_in = stored_ff + CNT_W'(1);
                  end
                  fin = last;
               end
            end
            MODE_QSEEN: begin
               if (is_quote) begin
                  if (room) begin
                     keep      = 1'b1;
                     stored_in = stored_ff + CNT_W'(1);
                  end
                  mode_in = MODE_QUOTED;
                  fin     = last;
               end else begin
                  mode_in = MODE_AFTER;
                  fin     = is_sep | last;
               end
            end
            MODE_AFTER: begin
               fin = is_sep | last;
            end
            MODE_PLAIN: begin
               if (is_sep) begin
                  fin = 1'b1;
               end else begin
                  if (room) begin
                     hold      = is_ws;
                     keep      = ~is_ws;
                     stored_in = stored_ff + CNT_W'(1);
                  end
                  fin = last;
               end
            end
            default: begin
               mode_in = MODE_LEAD;
               if (is_blank) begin
                  fin = last;
               end else if (is_quote) begin
                  mode_in = MODE_QUOTED;
                  fin     = last;
               end else if (is_sep) begin
                  fin = 1'b1;
               end else begin
                  mode_in = MODE_PLAIN;
                  if (room) begin
                     hold      = is_ws;
                     keep      = ~is_ws;
                     stored_in = stored_ff + CNT_W'(1);
                  end
                  fin = last;
               end
            end
         endcase
         if (fin) begin
            mode_in   = MODE_LEAD;
            stored_in = '0;
         end
      end
   end

   assign cmd_push      = accept & (keep | hold | fin);
   assign cmd_data.data = c;
   assign cmd_data.keep = keep;
   assign cmd_data.hold = hold;
   assign cmd_data.fin  = fin;
   assign cmd_data.last = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_LEAD;
         stored_ff    <= '0;
         separator_ff <= SEPARATOR_RESET;
      end else begin
         mode_ff   <= mode_in;
         stored_ff <= stored_in;
         if (csr_we) begin
            separator_ff <= csr_wdata;
         end
      end
   end

`ifndef SYNTHESIS
   a_stored_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= KEEP_MAX)
      else $error("stored count beyond field limit");
`endif

endmodule

### rtl/ctf_back.sv
`timescale 1ns / 1ps

module ctf_back #(
   parameter int FIELD_MAX = ctf_pkg::FIELD_MAX_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  ctf_pkg::cmd_type cmd,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output ctf_pkg::rsp_type res,
   output logic             res_push,
   input  logic             res_full
);

   import ctf_pkg::*;

   localparam int CNT_W = $clog2(FIELD_MAX);
   localparam int DEPTH = FIELD_MAX - 1;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] PEND_MAX = CNT_W'(FIELD_MAX - 1);

   logic [1:0]       kinds_mem [DEPTH];
   logic [1:0]       kind_rd_ff;
   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] pend_ff, pend_in;
   logic [CNT_W-1:0] flush_ff, flush_in;
   logic             wr_en;
   logic [IDX_W-1:0] rd_addr;
   rsp_type          byte_res, fin_res;

   assign byte_res = '{field_byte: cmd.data, byte_valid: 1'b1, field_end: 1'b0, line_end: 1'b0};
   assign fin_res  = '{field_byte: 8'd0, byte_valid: 1'b0, field_end: 1'b1, line_end: cmd.last};
   assign rd_addr  = flush_in[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      flush_in = flush_ff;
      cmd_pop  = 1'b0;
      res_push = 1'b0;
      res      = fin_res;
      wr_en    = 1'b0;
      unique case (state_ff)
         BACK_HEAD: begin
            if (!cmd_empty) begin
               if (cmd.keep && pend_ff != '0) begin
                  state_in = BACK_FLUSH;
                  flush_in = '0;
               end else if (cmd.keep) begin
                  if (!res_full) begin
                     res      = byte_res;
                     res_push = 1'b1;
                     if (cmd.fin) begin
                        state_in = BACK_FIN;
                     end else begin
                        cmd_pop = 1'b1;
                     end
                  end
               end else if (cmd.hold && !cmd.fin) begin
                  wr_en   = 1'b1;
                  pend_in = pend_ff + CNT_W'(1);
                  cmd_pop = 1'b1;
               end else if (cmd.fin) begin
                  if (!res_full) begin
                     res_push = 1'b1;
                     pend_in  = '0;
                     cmd_pop  = 1'b1;
                  end
               end else begin
                  cmd_pop = 1'b1;
               end
            end
         end
         BACK_FLUSH: begin
            if (!res_full) begin
               res      = '{field_byte: kind_char(kind_rd_ff), byte_valid: 1'b1,
                            field_end: 1'b0, line_end: 1'b0};
               res_push = 1'b1;
               if (flush_ff + CNT_W'(1) == pend_ff) begin
                  state_in = BACK_BYTE;
                  flush_in = '0;
                  pend_in  = '0;
               end else begin
                  flush_in = flush_ff + CNT_W'(1);
               end
            end
         end
         BACK_BYTE: begin
            if (!res_full) begin
               res      = byte_res;
               res_push = 1'b1;
               if (cmd.fin) begin
                  state_in = BACK_FIN;
               end else begin
                  cmd_pop  = 1'b1;
                  state_in = BACK_HEAD;
               end
            end
         end
         default: begin
            if (!res_full) begin
               res_push = 1'b1;
               pend_in  = '0;
               cmd_pop  = 1'b1;
               state_in = BACK_HEAD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_HEAD;
         pend_ff  <= '0;
         flush_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         flush_ff <= flush_in;
      end
   end

   // held whitespace store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         kinds_mem[pend_ff[IDX_W-1:0]] <= kind_of(cmd.data);
      end
      kind_rd_ff <= kinds_mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_flush_has_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_FLUSH |-> pend_ff != '0 && flush_ff < pend_ff)
      else $error("flush without held whitespace");

   a_field_end_clears: assert property (@(posedge clock) disable iff (reset)
      res_push && !res_full && res.field_end |=> pend_ff == '0)
      else $error("held whitespace survives field end");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_MAX)
      else $error("held whitespace count beyond limit");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ctf_pkg::*;

   localparam int FIELD_LIMIT   = FIELD_MAX_DEFAULT;
   localparam int MAX_TOKENS    = 64;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       csr_we    = 1'b0;
   logic [7:0] csr_wdata = SEPARATOR_RESET;
   logic       req_push  = 1'b0;
   logic       req_full;
   req_type    req_data  = '0;
   logic       rsp_pop   = 1'b0;
   logic       rsp_empty;
   rsp_type    rsp_data;

   // tokenizer state as the testbench tracks it
   logic [7:0] sep_reg     = SEPARATOR_RESET;
   mode_type   parse_state = MODE_LEAD;
   int         kept_bytes  = 0;
   int         held_count  = 0;
   logic [7:0] held_ws [0:FIELD_LIMIT-2];
   int         step_tokens = 0;

   rsp_type    expected_tokens[$];
   logic [7:0] line_q[$];
   int         mismatch_count = 0;
   int         requests_sent  = 0;
   bit         tx_idle_on     = 1'b1;
   bit         rx_idle_on     = 1'b1;
   int         rx_hold_left   = 0;
   int         rx_stall_left  = 0;

   csv_field_tokenizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   task automatic add_token(input logic [7:0] b, input logic v, input logic fe,
                            input logic le);
      rsp_type t;
      if (step_tokens < MAX_TOKENS) begin
         t.field_byte = b;
         t.byte_valid = v;
         t.field_end  = fe;
         t.line_end   = le;
         expected_tokens.push_back(t);
         step_tokens++;
      end
   endtask

   task automatic close_field(input logic last);
      add_token(8'h00, 1'b0, 1'b1, last);
      parse_state = MODE_LEAD;
      kept_bytes  = 0;
      held_count  = 0;
   endtask

   task automatic keep_quoted(input logic [7:0] c);
      if (kept_bytes < FIELD_LIMIT - 1) begin
         add_token(c, 1'b1, 1'b0, 1'b0);
         kept_bytes++;
      end
   endtask

   // trailing whitespace is held back until a later byte proves it inner
   task automatic keep_plain(input logic [7:0] c);
      if (kept_bytes < FIELD_LIMIT - 1) begin
         if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
            if (held_count < FIELD_LIMIT - 1) begin
               held_ws[held_count] = c;
               held_count++;
            end
         end else begin
            for (int k = 0; k < held_count; k++) begin
               add_token(held_ws[k], 1'b1, 1'b0, 1'b0);
            end
            held_count = 0;
            add_token(c, 1'b1, 1'b0, 1'b0);
         end
         kept_bytes++;
      end
   endtask

   task automatic tokenize_byte(input logic [7:0] c, input logic last);
      step_tokens = 0;
      case (parse_state)
         MODE_QUOTED: begin
            if (c == CHAR_QUOTE) begin
               if (last) close_field(1'b1);
               else parse_state = MODE_QSEEN;
            end else begin
               keep_quoted(c);
               if (last) close_field(1'b1);
            end
         end
         MODE_QSEEN: begin
            if (c == CHAR_QUOTE) begin
               keep_quoted(c);
               parse_state = MODE_QUOTED;
               if (last) close_field(1'b1);
            end else begin
               parse_state = MODE_AFTER;
               if (c == sep_reg || last) close_field(last);
            end
         end
         MODE_AFTER: begin
            if (c == sep_reg || last) close_field(last);
         end
         MODE_PLAIN: begin
            if (c == sep_reg) begin
               close_field(last);
            end else begin
               keep_plain(c);
               if (last) close_field(1'b1);
            end
         end
         default: begin
            parse_state = MODE_LEAD;
            if (c == CHAR_SPACE || c == CHAR_TAB) begin
               if (last) close_field(1'b1);
            end else if (c == CHAR_QUOTE) begin
               parse_state = MODE_QUOTED;
               if (last) close_field(1'b1);
            end else if (c == sep_reg) begin
               close_field(last);
            end else begin
               parse_state = MODE_PLAIN;
               keep_plain(c);
               if (last) close_field(1'b1);
            end
         end
      endcase
   endtask

   task automatic check_token(input rsp_type got);
      rsp_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch($sformatf("unexpected token %h", got));
         return;
      end
      want = expected_tokens.pop_front();
      if (got.field_byte !== want.field_byte)
         report_mismatch($sformatf("field_byte %h, want %h", got.field_byte, want.field_byte));
      if (got.byte_valid !== want.byte_valid)
         report_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
      if (got.field_end !== want.field_end)
         report_mismatch($sformatf("field_end %b, want %b", got.field_end, want.field_end));
      if (got.line_end !== want.line_end)
         report_mismatch($sformatf("line_end %b, want %b", got.line_end, want.line_end));
   endtask

   // receiver: checks each popped token and paces pop
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_token(rsp_data);
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_pop <= 1'b0;
         end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_pop <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 7);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_type r;
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      r.line_byte    = b;
      r.last_of_line = last;
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      tokenize_byte(b, last);
      requests_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_q.size(); i++) begin
         send_byte(line_q[i], i == line_q.size() - 1);
      end
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         line_q.push_back(s[i]);
      end
   endtask

   task automatic drain_tokens();
      req_push <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] v);
      drain_tokens();
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      sep_reg = v;
   endtask

   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 8'h61 + 8'($urandom_range(0, 25));
      else if (r == 10) return CHAR_SPACE;
      else if (r == 11) return CHAR_TAB;
      else if (r == 12) return CHAR_CR;
      else if (r == 13) return CHAR_LF;
      else if (r < 16) return CHAR_QUOTE;
      else if (r == 16) return sep_reg;
      else return 8'($urandom_range(0, 255));
   endfunction

   task automatic build_field(input int longest);
      int r;
      int n;
      logic [7:0] c;
      repeat ($urandom_range(0, 2)) line_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      r = $urandom_range(0, 9);
      if (r < 3) begin
         line_q.push_back(CHAR_QUOTE);
         n = $urandom_range(0, longest);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
               line_q.push_back(CHAR_QUOTE);
               line_q.push_back(CHAR_QUOTE);
            end else begin
               c = text_byte();
               line_q.push_back(c == CHAR_QUOTE ? 8'h71 : c);
            end
         end
         if ($urandom_range(0, 4) != 0) line_q.push_back(CHAR_QUOTE);
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(text_byte());
      end else if (r == 3) begin
         if ($urandom_range(0, 1) == 1) line_q.push_back(CHAR_SPACE);
      end else begin
         repeat ($urandom_range(1, longest)) line_q.push_back(text_byte());
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
               0: line_q.push_back(CHAR_SPACE);
               1: line_q.push_back(CHAR_TAB);
               2: line_q.push_back(CHAR_CR);
               default: line_q.push_back(CHAR_LF);
            endcase
         end
      end
   endtask

   task automatic build_line(input int longest);
      int fields;
      line_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         fields = $urandom_range(1, 4);
         for (int f = 0; f < fields; f++) begin
            if (f != 0) line_q.push_back(sep_reg);
            build_field(longest);
         end
         if ($urandom_range(0, 7) == 0) line_q.push_back(sep_reg);
      end
      if (line_q.size() == 0) line_q.push_back(8'h7a);
   endtask

   task automatic test_basic_fields();
      line_q.delete();
      add_text(" \tab ");
      line_q.push_back(CHAR_CR);
      add_text(",\"q\"\"r\"zz,");
      send_line();
   endtask

   task automatic test_quote_cases();
      line_q.delete();
      add_text("\"un");
      send_line();
      line_q.delete();
      add_text("\"");
      send_line();
      line_q.delete();
      add_text(" \t");
      send_line();
      line_q.delete();
      add_text("x");
      line_q.push_back(CHAR_LF);
      add_text("y");
      send_line();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
   endtask

   task automatic test_separator_settings();
      logic [7:0] seps [7];
      seps = '{8'h3b, CHAR_QUOTE, CHAR_SPACE, CHAR_TAB, 8'h00, 8'hff, SEPARATOR_RESET};
      foreach (seps[i]) begin
         write_separator(seps[i]);
         build_line(4);
         send_line();
      end
   endtask

   task automatic test_random_lines();
      int stop_at;
      stop_at = requests_sent + 60;
      while (requests_sent < stop_at) begin
         build_line(8);
         send_line();
      end
   endtask

   task automatic test_long_fields();
      // big whitespace flush followed by truncation
      line_q.delete();
      line_q.push_back(8'h61);
      repeat (61) line_q.push_back(CHAR_SPACE);
      add_text("bcd");
      send_line();
      // quoted field of 34 doubled quotes, within the limit, then text after the closing quote
      line_q.delete();
      line_q.push_back(CHAR_QUOTE);
      repeat (34) begin
         line_q.push_back(CHAR_QUOTE);
         line_q.push_back(CHAR_QUOTE);
      end
      add_text("\"tail,z");
      send_line();
   endtask

   task automatic test_full_stall();
      drain_tokens();
      tx_idle_on = 1'b0;
      rx_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 40; i++) begin
         send_byte(8'h41 + 8'(i % 26), (i % 10) == 9);
      end
      tx_idle_on = 1'b1;
      drain_tokens();
   endtask

   task automatic test_streaming();
      int stop_at;
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      stop_at = requests_sent + 50;
      while (requests_sent < stop_at) begin
         build_line(8);
         send_line();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_fields();
      test_quote_cases();
      test_separator_settings();
      test_random_lines();
      test_long_fields();
      test_full_stall();
      test_streaming();
      req_push <= 1'b0;
      for (int i = 0; i < 100000 && expected_tokens.size() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
      end
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
rtl/ctf_pkg.sv
rtl/ctf_fifo.sv
rtl/ctf_front.sv
rtl/ctf_back.sv
rtl/csv_field_tokenizer_top.sv
sim/tb_top.sv
